// ===== sv/infix_to_postfix_converter_defines.svh =====
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_defines.svh
// assertion macros shared by the converter rtl
// ----------------------------------------------------------------------------
`ifndef INFIX_TO_POSTFIX_CONVERTER_DEFINES_SVH
`define INFIX_TO_POSTFIX_CONVERTER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define ITP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define ITP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/itp_pkg.sv =====
// ----------------------------------------------------------------------------
// itp_pkg
// types, codes and character tables of the infix to postfix converter
// ----------------------------------------------------------------------------
package itp_pkg;

  typedef enum logic [2:0] {
    OPC_OPEN = 3'd0,
    OPC_ADD  = 3'd1,
    OPC_SUB  = 3'd2,
    OPC_MUL  = 3'd3,
    OPC_DIV  = 3'd4,
    OPC_POW  = 3'd5
  } opcode_e;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_OVERFLOW = 3'd1,
    ERR_CLOSE    = 3'd2,
    ERR_CHAR     = 3'd3,
    ERR_OPEN     = 3'd4
  } err_e;

  typedef enum logic [2:0] {
    CL_ALNUM,
    CL_OPEN,
    CL_CLOSE,
    CL_OPER,
    CL_BAD
  } sym_class_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_FLUSH
  } state_e;

  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_ADD   = 8'h2B;
  localparam logic [7:0] CH_SUB   = 8'h2D;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_POW   = 8'h5E;

  typedef struct packed {
    logic [7:0] sym;
    logic       has;
    logic       last;
    logic [2:0] err;
  } res_t;

  function automatic logic [7:0] op_char(input logic [2:0] code);
    logic [7:0] c;
    unique case (code)
      OPC_OPEN: c = CH_OPEN;
      OPC_ADD:  c = CH_ADD;
      OPC_SUB:  c = CH_SUB;
      OPC_MUL:  c = CH_MUL;
      OPC_DIV:  c = CH_DIV;
      OPC_POW:  c = CH_POW;
      default:  c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [1:0] op_prec(input logic [2:0] code);
    logic [1:0] p;
    unique case (code)
      OPC_ADD, OPC_SUB: p = 2'd1;
      OPC_MUL, OPC_DIV: p = 2'd2;
      OPC_POW:          p = 2'd3;
      default:          p = 2'd0;
    endcase
    return p;
  endfunction

  function automatic logic [2:0] op_code(input logic [7:0] c);
    logic [2:0] code;
    unique case (c)
      CH_ADD:  code = OPC_ADD;
      CH_SUB:  code = OPC_SUB;
      CH_MUL:  code = OPC_MUL;
      CH_DIV:  code = OPC_DIV;
      CH_POW:  code = OPC_POW;
      default: code = OPC_OPEN;
    endcase
    return code;
  endfunction

  function automatic sym_class_e classify(input logic [7:0] c);
    sym_class_e cl;
    priority if ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
                 (c >= 8'h61 && c <= 8'h7A)) cl = CL_ALNUM;
    else if (c == CH_OPEN)                    cl = CL_OPEN;
    else if (c == CH_CLOSE)                   cl = CL_CLOSE;
    else if (op_code(c) != OPC_OPEN)          cl = CL_OPER;
    else                                      cl = CL_BAD;
    return cl;
  endfunction

endpackage

// ===== sv/itp_req_if.sv =====
// ----------------------------------------------------------------------------
// itp_req_if
// request channel carrying one infix character or an end marker
// ----------------------------------------------------------------------------
interface itp_req_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       end_of_expression;

  modport source (output valid, symbol, end_of_expression, input ready);
  modport sink   (input valid, symbol, end_of_expression, output ready);
endinterface

// ===== sv/itp_res_if.sv =====
// ----------------------------------------------------------------------------
// itp_res_if
// result channel carrying one postfix character or a report
// ----------------------------------------------------------------------------
interface itp_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_symbol;
  logic       has_symbol;
  logic       last_of_run;
  logic [2:0] error_code;

  modport source (output valid, out_symbol, has_symbol, last_of_run, error_code,
                  input ready);
  modport sink   (input valid, out_symbol, has_symbol, last_of_run, error_code,
                  output ready);
endinterface

// ===== sv/infix_to_postfix_converter.sv =====
// a request is taken in ST_IDLE and evaluated from the next cycle on in ST_EVAL;
// each stack step (pop, push or report) is one ST_EVAL step against the stack
// memory, a closing result that follows popped operators goes out from
// ST_FLUSH, and a result stall holds any step that must move a result.
// reset clears the fill count and control state; the stack memory is not
// cleared, only entries below the fill count are ever used.
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// shunting-yard infix to postfix conversion with the operator stack in memory
// ----------------------------------------------------------------------------
`include "infix_to_postfix_converter_defines.svh"

module infix_to_postfix_converter #(
  parameter int STACK_DEPTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  itp_req_if.sink    req_i,
  itp_res_if.source  res_o
);
  import itp_pkg::*;

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [2:0]    mem [STACK_DEPTH];
  logic [2:0]    rdata_q;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [2:0]    wr_data;

  state_e        state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [7:0]    sym_q;
  logic          eoe_q;
  logic          open_left_q, open_left_d;
  res_t          pend_q, pend_d;
  logic          pend_valid_q, pend_valid_d;
  res_t          out_q, out_d;
  logic          out_valid_q, out_valid_d;

  // decision of one evaluation step
  logic          emit_v;
  res_t          emit_r;
  logic          final_v;
  logic          pop_v;
  logic          push_v;
  logic [2:0]    push_code;
  logic          set_open;
  logic          has_top;
  logic          open_top;
  logic          full;
  logic          out_free;
  logic          fire;
  logic          accept;
  sym_class_e    cl;

  assign has_top  = (count_q != '0);
  assign open_top = (rdata_q == OPC_OPEN);
  assign full     = (count_q == CW'(STACK_DEPTH));
  assign out_free = !out_valid_q || res_o.ready;
  assign accept   = req_i.valid && req_i.ready;
  assign cl       = classify(sym_q);

  always_comb begin
    emit_v    = 1'b0;
    emit_r    = '{sym: 8'h00, has: 1'b0, last: 1'b0, err: ERR_NONE};
    final_v   = 1'b0;
    pop_v     = 1'b0;
    push_v    = 1'b0;
    push_code = OPC_OPEN;
    set_open  = 1'b0;
    if (eoe_q) begin
      if (!has_top) begin
        emit_v     = 1'b1;
        emit_r.err = open_left_q ? ERR_OPEN : ERR_NONE;
        final_v    = 1'b1;
      end else if (open_top) begin
        pop_v    = 1'b1;
        set_open = 1'b1;
      end else begin
        emit_v     = 1'b1;
        emit_r.sym = op_char(rdata_q);
        emit_r.has = 1'b1;
        pop_v      = 1'b1;
      end
    end else begin
      unique case (cl)
        CL_ALNUM: begin
          emit_v     = 1'b1;
          emit_r.sym = sym_q;
          emit_r.has = 1'b1;
          final_v    = 1'b1;
        end
        CL_OPEN: begin
          final_v = 1'b1;
          if (full) begin
            emit_v     = 1'b1;
            emit_r.err = ERR_OVERFLOW;
          end else begin
            push_v = 1'b1;
          end
        end
        CL_CLOSE: begin
          priority if (has_top && !open_top) begin
            emit_v     = 1'b1;
            emit_r.sym = op_char(rdata_q);
            emit_r.has = 1'b1;
            pop_v      = 1'b1;
          end else if (has_top) begin
            pop_v   = 1'b1;
            final_v = 1'b1;
          end else begin
            emit_v     = 1'b1;
            emit_r.err = ERR_CLOSE;
            final_v    = 1'b1;
          end
        end
        CL_OPER: begin
          priority if (has_top && !open_top && op_prec(rdata_q) >= op_prec(op_code(sym_q)))
          begin
            emit_v     = 1'b1;
            emit_r.sym = op_char(rdata_q);
            emit_r.has = 1'b1;
            pop_v      = 1'b1;
          end else if (full) begin
            emit_v     = 1'b1;
            emit_r.err = ERR_OVERFLOW;
            final_v    = 1'b1;
          end else begin
            push_v    = 1'b1;
            push_code = op_code(sym_q);
            final_v   = 1'b1;
          end
        end
        default: begin
          emit_v     = 1'b1;
          emit_r.err = ERR_CHAR;
          final_v    = 1'b1;
        end
      endcase
    end
  end

  // a step that must move a result into the output register waits for it
  assign fire = (state_q == ST_EVAL) &&
                !((emit_v || (final_v && pend_valid_q)) && !out_free);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (req_i.valid) state_d = ST_EVAL;
      ST_EVAL: begin
        if (fire && final_v) state_d = (emit_v && pend_valid_q) ? ST_FLUSH : ST_IDLE;
      end
      ST_FLUSH: if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    count_d      = count_q;
    open_left_d  = open_left_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && !res_o.ready;
    wr_en        = 1'b0;
    wr_data      = push_code;
    req_i.ready  = (state_q == ST_IDLE);

    if (accept) open_left_d = 1'b0;

    if (fire) begin
      if (pop_v)    count_d     = count_q - CW'(1);
      if (push_v) begin
        count_d = count_q + CW'(1);
        wr_en   = 1'b1;
      end
      if (set_open) open_left_d = 1'b1;
      // the newest result is held back until it is known whether it is last
      if (emit_v) begin
        if (pend_valid_q) begin
          out_d        = pend_q;
          out_d.last   = 1'b0;
          out_valid_d  = 1'b1;
          pend_d       = emit_r;
          pend_valid_d = 1'b1;
        end else if (final_v) begin
          out_d       = emit_r;
          out_d.last  = 1'b1;
          out_valid_d = 1'b1;
        end else begin
          pend_d       = emit_r;
          pend_valid_d = 1'b1;
        end
      end else if (final_v && pend_valid_q) begin
        out_d        = pend_q;
        out_d.last   = 1'b1;
        out_valid_d  = 1'b1;
        pend_valid_d = 1'b0;
      end
    end

    if (state_q == ST_FLUSH && out_free) begin
      out_d        = pend_q;
      out_d.last   = 1'b1;
      out_valid_d  = 1'b1;
      pend_valid_d = 1'b0;
    end

    rd_addr = (count_d != '0) ? AW'(count_d - CW'(1)) : '0;
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.out_symbol  = out_q.sym;
  assign res_o.has_symbol  = out_q.has;
  assign res_o.last_of_run = out_q.last;
  assign res_o.error_code  = out_q.err;

  // stack memory, registered read of the entry below the next fill count
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[AW'(count_q)] <= wr_data;
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      open_left_q  <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      open_left_q  <= open_left_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sym_q <= req_i.symbol;
      eoe_q <= req_i.end_of_expression;
    end
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  `ITP_ASSERT_NOW(a_count_range, 1'b1, count_q <= CW'(STACK_DEPTH), "fill count beyond depth")
  `ITP_ASSERT_NOW(a_idle_clean, req_i.ready, !pend_valid_q, "held result while taking a request")
  `ITP_ASSERT_NOW(a_err_no_sym, out_valid_q && out_q.has, out_q.err == ERR_NONE, "error on char")
  `ITP_ASSERT_NXT(a_push_count, fire && push_v, count_q == $past(count_q) + CW'(1), "push lost")

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// checks the shunting-yard converter: infix requests go in, and every postfix
// result coming back is compared against a local operator-stack model
// ----------------------------------------------------------------------------
module tb;
  import itp_pkg::*;

  localparam int STACK_DEPTH    = 32;
  localparam int N_ITEMS        = 310;
  localparam int CALM_TAIL      = 40;
  localparam int LONG_HOLD      = 250;
  localparam int DRAIN_CYCLES   = 2 * STACK_DEPTH + 16;
  localparam int WATCHDOG_LIMIT = 3000;

  typedef struct packed {
    logic [7:0] sym;
    logic       eoe;
  } infix_item_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  itp_req_if req_if ();
  itp_res_if res_if ();

  infix_to_postfix_converter #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_top (
    .clk_i,
    .rst_ni,
    .req_i(req_if),
    .res_o(res_if)
  );

  infix_item_t char_q[$];
  res_t        postfix_q[$];
  res_t        want_res;

  // model of the operator stack
  opcode_e opstk[STACK_DEPTH];
  int      opcnt = 0;

  int mismatch_cnt = 0;
  int sent_cnt     = 0;
  int seen_cnt     = 0;
  int rx_cnt       = 0;
  int total_items  = 0;
  int idle_cycles  = 0;
  int tx_gap       = 0;
  int rx_gap       = 0;
  int hold_left    = 0;
  bit hold_done    = 1'b0;

  always #1 clk_i = ~clk_i;

  function automatic logic [7:0] sym_of_op(input opcode_e op);
    case (op)
      OPC_ADD: return CH_ADD;
      OPC_SUB: return CH_SUB;
      OPC_MUL: return CH_MUL;
      OPC_DIV: return CH_DIV;
      OPC_POW: return CH_POW;
      default: return CH_OPEN;
    endcase
  endfunction

  function automatic int rank_of_op(input opcode_e op);
    case (op)
      OPC_ADD, OPC_SUB: return 1;
      OPC_MUL, OPC_DIV: return 2;
      OPC_POW:          return 3;
      default:          return 0;
    endcase
  endfunction

  function automatic bit is_operand(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic void push_result(input logic [7:0] s, input logic h, input err_e e);
    res_t r;
    r.sym  = s;
    r.has  = h;
    r.last = 1'b0;
    r.err  = e;
    postfix_q.push_back(r);
  endfunction

  function automatic void pop_operator();
    opcnt--;
    push_result(sym_of_op(opstk[opcnt]), 1'b1, ERR_NONE);
  endfunction

  // expected postfix results for one accepted request
  function automatic void shunt_predict(input infix_item_t it);
    int      n0;
    bit      open_left;
    opcode_e op;
    int      p;
    res_t    r;
    n0        = postfix_q.size();
    open_left = 1'b0;
    if (it.eoe) begin
      while (opcnt > 0) begin
        if (opstk[opcnt-1] == OPC_OPEN) begin
          opcnt--;
          open_left = 1'b1;
        end else begin
          pop_operator();
        end
      end
      push_result(8'h00, 1'b0, open_left ? ERR_OPEN : ERR_NONE);
    end else if (is_operand(it.sym)) begin
      push_result(it.sym, 1'b1, ERR_NONE);
    end else if (it.sym == CH_OPEN) begin
      if (opcnt >= STACK_DEPTH) begin
        push_result(8'h00, 1'b0, ERR_OVERFLOW);
      end else begin
        opstk[opcnt] = OPC_OPEN;
        opcnt++;
      end
    end else if (it.sym == CH_CLOSE) begin
      while (opcnt > 0 && opstk[opcnt-1] != OPC_OPEN) pop_operator();
      if (opcnt > 0) opcnt--;
      else push_result(8'h00, 1'b0, ERR_CLOSE);
    end else begin
      case (it.sym)
        CH_ADD:  op = OPC_ADD;
        CH_SUB:  op = OPC_SUB;
        CH_MUL:  op = OPC_MUL;
        CH_DIV:  op = OPC_DIV;
        CH_POW:  op = OPC_POW;
        default: op = OPC_OPEN;
      endcase
      if (op == OPC_OPEN) begin
        push_result(8'h00, 1'b0, ERR_CHAR);
      end else begin
        p = rank_of_op(op);
        // an open bracket, an empty stack or a lower-ranked operator stops the popping
        while (opcnt > 0 && opstk[opcnt-1] != OPC_OPEN && rank_of_op(opstk[opcnt-1]) >= p)
          pop_operator();
        if (opcnt >= STACK_DEPTH) begin
          push_result(8'h00, 1'b0, ERR_OVERFLOW);
        end else begin
          opstk[opcnt] = op;
          opcnt++;
        end
      end
    end
    if (postfix_q.size() > n0) begin
      r      = postfix_q.pop_back();
      r.last = 1'b1;
      postfix_q.push_back(r);
    end
  endfunction

  task automatic flag_mismatch(input string what, input logic [7:0] got, input logic [7:0] want);
    mismatch_cnt++;
    $display("mismatch at result %0d: %s got 0x%0h want 0x%0h", rx_cnt, what, got, want);
  endtask

  // stimulus helpers
  task automatic put(input logic [7:0] s, input bit e = 1'b0);
    char_q.push_back('{sym: s, eoe: e});
  endtask

  task automatic put_str(input string s);
    foreach (s[i]) put(s[i]);
  endtask

  // symbol of an end request is don't-care, so it gets a random byte
  task automatic put_end();
    put(8'($urandom_range(0, 255)), 1'b1);
  endtask

  function automatic logic [7:0] rand_operand();
    case ($urandom_range(0, 2))
      0:       return 8'h30 + 8'($urandom_range(0, 9));
      1:       return 8'h41 + 8'($urandom_range(0, 25));
      default: return 8'h61 + 8'($urandom_range(0, 25));
    endcase
  endfunction

  function automatic logic [7:0] rand_operator();
    case ($urandom_range(0, 4))
      0:       return CH_ADD;
      1:       return CH_SUB;
      2:       return CH_MUL;
      3:       return CH_DIV;
      default: return CH_POW;
    endcase
  endfunction

  task automatic gen_expr(input int depth);
    int terms;
    terms = $urandom_range(1, 4);
    for (int i = 0; i < terms; i++) begin
      if (i > 0) put(rand_operator());
      if ($urandom_range(0, 19) == 0) put(8'($urandom_range(0, 255)));
      if (depth < 5 && $urandom_range(0, 3) == 0) begin
        put(CH_OPEN);
        gen_expr(depth + 1);
        put(CH_CLOSE);
      end else begin
        put(rand_operand());
      end
    end
  endtask

  task automatic gen_noise();
    int n;
    n = $urandom_range(1, 6);
    repeat (n) begin
      case ($urandom_range(0, 3))
        0:       put(8'($urandom_range(0, 255)));
        1:       put($urandom_range(0, 1) ? CH_OPEN : CH_CLOSE);
        2:       put(rand_operator());
        default: put(rand_operand());
      endcase
    end
    put_end();
  endtask

  // request driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid             <= 1'b0;
      req_if.symbol            <= 8'h00;
      req_if.end_of_expression <= 1'b0;
    end else if (!req_if.valid || sent_cnt != seen_cnt) begin
      seen_cnt = sent_cnt;
      if (tx_gap > 0) begin
        tx_gap--;
        req_if.valid <= 1'b0;
      end else if (char_q.size() == 0) begin
        req_if.valid <= 1'b0;
      end else if (sent_cnt < total_items - CALM_TAIL && $urandom_range(0, 5) == 0) begin
        tx_gap = $urandom_range(0, 8);
        req_if.valid <= 1'b0;
      end else begin
        req_if.valid             <= 1'b1;
        req_if.symbol            <= char_q[0].sym;
        req_if.end_of_expression <= char_q[0].eoe;
      end
    end
  end

  // result receiver, with one long hold-off to back up the block
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      res_if.ready <= 1'b0;
    end else if (!hold_done && rx_cnt >= 30) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD - 1;
      res_if.ready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      res_if.ready <= 1'b0;
    end else if (sent_cnt < total_items - CALM_TAIL && $urandom_range(0, 5) == 0) begin
      rx_gap = $urandom_range(0, 8);
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  // monitor, checker and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      idle_cycles++;
      if (req_if.valid && req_if.ready) begin
        shunt_predict('{sym: req_if.symbol, eoe: req_if.end_of_expression});
        void'(char_q.pop_front());
        sent_cnt++;
        idle_cycles = 0;
      end
      if (res_if.valid && res_if.ready) begin
        idle_cycles = 0;
        rx_cnt++;
        if (postfix_q.size() == 0) begin
          flag_mismatch("result with nothing pending", res_if.out_symbol, 8'h00);
        end else begin
          want_res = postfix_q.pop_front();
          if (res_if.out_symbol !== want_res.sym)
            flag_mismatch("out_symbol", res_if.out_symbol, want_res.sym);
          if (res_if.has_symbol !== want_res.has)
            flag_mismatch("has_symbol", 8'(res_if.has_symbol), 8'(want_res.has));
          if (res_if.last_of_run !== want_res.last)
            flag_mismatch("last_of_run", 8'(res_if.last_of_run), 8'(want_res.last));
          if (res_if.error_code !== want_res.err)
            flag_mismatch("error_code", 8'(res_if.error_code), 8'(want_res.err));
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;

    // directed: precedence, brackets, bad characters, open left at end
    put_str("a+b*c");
    put_end();
    put_str("(A-9)/Z^0");
    put_end();
    put_str("a+)");
    put_end();
    put(8'h00);
    put(8'hFF);
    put_str("((z");
    put_end();
    put_end();

    // stack overflow on brackets, then on an operator push
    repeat (STACK_DEPTH + 2) put(CH_OPEN);
    put_str("x*");
    put_end();
    repeat (STACK_DEPTH - 1) put(CH_OPEN);
    put_str("a+b*c)");
    put_end();

    // mostly well-formed expressions, some junk
    while (char_q.size() < N_ITEMS) begin
      if ($urandom_range(0, 4) != 0) begin
        gen_expr(0);
        put_end();
      end else begin
        gen_noise();
      end
    end
    total_items = char_q.size();

    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    while (char_q.size() != 0) @(posedge clk_i);
    while (postfix_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_cnt == 0 && postfix_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
